/* rtl/quoted_argument_tokenizer_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the quoted argument tokenizer
// Shared helpers that wrap a clocked implication with reset masking.
// ----------------------------------------------------------------------------
`ifndef QUOTED_ARGUMENT_TOKENIZER_TOP_MACROS_SVH
`define QUOTED_ARGUMENT_TOKENIZER_TOP_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define QAT_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("qat assertion failed");

// Next-cycle implication, masked while reset is high.
`define QAT_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("qat assertion failed");

`endif

/* rtl/qat_pkg.sv */
// ----------------------------------------------------------------------------
// qat_pkg
// Types and constants shared by the quoted argument tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package qat_pkg;

   localparam int MaxResults  = 4;
   localparam int ResIdxWidth = 2;
   localparam int ResNumWidth = 3;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_BEL   = 8'h07;
   localparam logic [7:0] CHAR_BS    = 8'h08;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DQUOT = 8'h22;
   localparam logic [7:0] CHAR_SQUOT = 8'h27;
   localparam logic [7:0] CHAR_BSL   = 8'h5C;
   localparam logic [7:0] CHAR_LC_A  = 8'h61;
   localparam logic [7:0] CHAR_LC_B  = 8'h62;
   localparam logic [7:0] CHAR_LC_N  = 8'h6E;
   localparam logic [7:0] CHAR_LC_R  = 8'h72;
   localparam logic [7:0] CHAR_LC_T  = 8'h74;
   localparam logic [7:0] CHAR_LC_X  = 8'h78;

   typedef enum logic [3:0] {
      MODE_SKIP,
      MODE_UQ,
      MODE_DQ,
      MODE_DQ_BSL,
      MODE_DQ_X,
      MODE_DQ_XH,
      MODE_DQ_CLOSE,
      MODE_SQ,
      MODE_SQ_BSL,
      MODE_SQ_CLOSE,
      MODE_IGNORE
   } qat_mode_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_line;
   } qat_req_type;

   typedef struct packed {
      logic [7:0] token_byte;
      logic       byte_valid;
      logic       token_done;
      logic       token_abort;
      logic       line_done;
      logic       last_result;
   } qat_rsp_type;

   typedef struct packed {
      qat_rsp_type [MaxResults-1:0] res;
      logic [ResNumWidth-1:0]       num;
   } qat_entry_type;

endpackage

`default_nettype wire

/* rtl/quoted_argument_tokenizer_top.sv */
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer_top
// Splits a command line, one byte per item, into quoted or unquoted
// arguments and delivers decoded argument bytes and argument end marks.
//
//   Channel | Direction | Payload      | Handshake
//   req_    | in        | qat_req_type | req_valid / req_stall
//   rsp_    | out       | qat_rsp_type | rsp_valid / rsp_stall
//
// The front takes one byte every cycle while the result queue has room.
// A byte yields zero to four results; the back delivers one result a cycle
// while the result channel is not stalled.
// A byte's results pass through the result queue and the back's output register.
// Reset is synchronous; there is no clearing pass.
// req_stall is high exactly while the result queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_argument_tokenizer_top #(
   parameter int QueueDepth = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  qat_pkg::qat_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output qat_pkg::qat_rsp_type rsp_data
);
   import qat_pkg::*;

   logic          q_push;
   logic          q_pop;
   logic          q_full;
   logic          q_empty;
   qat_entry_type q_push_data;
   qat_entry_type q_pop_data;

   qat_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_push_data)
   );

   qat_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   qat_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_data    (q_pop_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* rtl/qat_queue.sv */
// ----------------------------------------------------------------------------
// qat_queue
// Short first-in first-out queue of decoded result groups between the
// classifying front and the output back.
// ----------------------------------------------------------------------------
`default_nettype none

module qat_queue #(
   parameter int Depth = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  qat_pkg::qat_entry_type push_data,
   input  logic                  pop,
   output qat_pkg::qat_entry_type pop_data,
   output logic                  full,
   output logic                  empty
);
   import qat_pkg::*;

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);

   qat_entry_type         mem_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;
   logic                  do_push;
   logic                  do_pop;

   assign full     = (cnt_ff == CntWidth'(Depth));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CntWidth'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/qat_front.sv */
// ----------------------------------------------------------------------------
// qat_front
// Accepts command line bytes, runs the parse mode machine and builds the
// group of results that each byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module qat_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  qat_pkg::qat_req_type   req_data,
   input  logic                   q_full,
   output logic                   q_push,
   output qat_pkg::qat_entry_type q_data
);
   import qat_pkg::*;

   typedef struct packed {
      qat_mode_type mode;
      logic [7:0]   held;
   } state_type;

   typedef struct packed {
      state_type     st;
      qat_entry_type ent;
   } walk_type;

   function automatic logic is_ws(logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   function automatic logic is_hex(logic [7:0] c);
      return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66))
          || ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   function automatic logic [3:0] hex_val(logic [7:0] c);
      return c[6] ? (c[3:0] + 4'd9) : c[3:0];
   endfunction

   function automatic logic [7:0] map_escape(logic [7:0] c);
      logic [7:0] r;
      case (c)
         CHAR_LC_N: r = CHAR_LF;
         CHAR_LC_R: r = CHAR_CR;
         CHAR_LC_T: r = CHAR_TAB;
         CHAR_LC_B: r = CHAR_BS;
         CHAR_LC_A: r = CHAR_BEL;
         default:   r = c;
      endcase
      return r;
   endfunction

   function automatic qat_entry_type add(qat_entry_type e, logic [7:0] b, logic v,
                                         logic d, logic a, logic l);
      qat_entry_type r;
      r = e;
      if (r.num < ResNumWidth'(MaxResults)) begin
         r.res[r.num[ResIdxWidth-1:0]] = '{token_byte: b, byte_valid: v, token_done: d,
                                           token_abort: a, line_done: l, last_result: 1'b0};
         r.num = r.num + ResNumWidth'(1);
      end
      return r;
   endfunction

   function automatic walk_type feed(walk_type w_start, logic [7:0] c);
      walk_type w;
      logic     again;
      w     = w_start;
      again = 1'b1;
      for (int i = 0; i < 2; i++) begin
         if (again) begin
            again = 1'b0;
            case (w.st.mode)
               MODE_SKIP: begin
                  if (c == CHAR_NUL) begin
                     w.ent     = add(w.ent, CHAR_NUL, 1'b0, 1'b0, 1'b0, 1'b1);
                     w.st.mode = MODE_IGNORE;
                  end else if (!is_ws(c) && !c[7]) begin
                     w.st.mode = MODE_UQ;
                     again     = 1'b1;
                  end
               end
               MODE_UQ: begin
                  if (c == CHAR_SPACE || c == CHAR_LF || c == CHAR_CR || c == CHAR_TAB) begin
                     w.ent     = add(w.ent, CHAR_NUL, 1'b0, 1'b1, 1'b0, 1'b0);
                     w.st.mode = MODE_SKIP;
                  end else if (c == CHAR_NUL) begin
                     w.ent     = add(w.ent, CHAR_NUL, 1'b0, 1'b1, 1'b0, 1'b1);
                     w.st.mode = MODE_IGNORE;
                  end else if (c == CHAR_DQUOT) begin
                     w.st.mode = MODE_DQ;
                  end else if (c == CHAR_SQUOT) begin
                     w.st.mode = MODE_SQ;
                  end else begin
                     w.ent = add(w.ent, c, 1'b1, 1'b0, 1'b0, 1'b0);
                  end
               end
               MODE_DQ: begin
                  if (c == CHAR_BSL) begin
                     w.st.mode = MODE_DQ_BSL;
                  end else if (c == CHAR_DQUOT) begin
                     w.st.mode = MODE_DQ_CLOSE;
                  end else if (c == CHAR_NUL) begin
                     w.ent     = add(w.ent, CHAR_NUL, 1'b0, 1'b0, 1'b1, 1'b1);
                     w.st.mode = MODE_IGNORE;
                     w.st.held = '0;
                  end else begin
                     w.ent = add(w.ent, c, 1'b1, 1'b0, 1'b0, 1'b0);
                  end
               end
               MODE_DQ_BSL: begin
                  if (c == CHAR_NUL) begin
                     w.ent     = add(w.ent, CHAR_BSL, 1'b1, 1'b0, 1'b0, 1'b0);
                     w.ent     = add(w.ent, CHAR_NUL, 1'b0, 1'b0, 1'b1, 1'b1);
                     w.st.mode = MODE_IGNORE;
                     w.st.held = '0;
                  end else if (c == CHAR_LC_X) begin
                     w.st.mode = MODE_DQ_X;
                  end else begin
                     w.ent     = add(w.ent, map_escape(c), 1'b1, 1'b0, 1'b0, 1'b0);
                     w.st.mode = MODE_DQ;
                  end
               end
               MODE_DQ_X: begin
                  if (is_hex(c)) begin
                     w.st.held = c;
                     w.st.mode = MODE_DQ_XH;
                  end else begin
                     w.ent     = add(w.ent, CHAR_LC_X, 1'b1, 1'b0, 1'b0, 1'b0);
                     w.st.mode = MODE_DQ;
                     again     = 1'b1;
                  end
               end
               MODE_DQ_XH: begin
                  if (is_hex(c)) begin
                     w.ent     = add(w.ent, {hex_val(w.st.held), hex_val(c)},
                                     1'b1, 1'b0, 1'b0, 1'b0);
                     w.st.held = '0;
                     w.st.mode = MODE_DQ;
                  end else begin
                     w.ent     = add(w.ent, CHAR_LC_X, 1'b1, 1'b0, 1'b0, 1'b0);
                     w.ent     = add(w.ent, w.st.held, 1'b1, 1'b0, 1'b0, 1'b0);
                     w.st.held = '0;
                     w.st.mode = MODE_DQ;
                     again     = 1'b1;
                  end
               end
               MODE_DQ_CLOSE, MODE_SQ_CLOSE: begin
                  if (c == CHAR_NUL) begin
                     w.ent     = add(w.ent, CHAR_NUL, 1'b0, 1'b1, 1'b0, 1'b1);
                     w.st.mode = MODE_IGNORE;
                  end else if (is_ws(c)) begin
                     w.ent     = add(w.ent, CHAR_NUL, 1'b0, 1'b1, 1'b0, 1'b0);
                     w.st.mode = MODE_SKIP;
                  end else begin
                     w.ent     = add(w.ent, CHAR_NUL, 1'b0, 1'b0, 1'b1, 1'b1);
                     w.st.mode = MODE_IGNORE;
                     w.st.held = '0;
                  end
               end
               MODE_SQ: begin
                  if (c == CHAR_BSL) begin
                     w.st.mode = MODE_SQ_BSL;
                  end else if (c == CHAR_SQUOT) begin
                     w.st.mode = MODE_SQ_CLOSE;
                  end else if (c == CHAR_NUL) begin
                     w.ent     = add(w.ent, CHAR_NUL, 1'b0, 1'b0, 1'b1, 1'b1);
                     w.st.mode = MODE_IGNORE;
                     w.st.held = '0;
                  end else begin
                     w.ent = add(w.ent, c, 1'b1, 1'b0, 1'b0, 1'b0);
                  end
               end
               MODE_SQ_BSL: begin
                  if (c == CHAR_SQUOT) begin
                     w.ent     = add(w.ent, CHAR_SQUOT, 1'b1, 1'b0, 1'b0, 1'b0);
                     w.st.mode = MODE_SQ;
                  end else begin
                     w.ent     = add(w.ent, CHAR_BSL, 1'b1, 1'b0, 1'b0, 1'b0);
                     w.st.mode = MODE_SQ;
                     again     = 1'b1;
                  end
               end
               default: begin
                  w.st.mode = MODE_IGNORE;
               end
            endcase
         end
      end
      return w;
   endfunction

   qat_mode_type mode_ff, mode_in;
   logic [7:0]   held_ff, held_in;
   logic         accept;
   walk_type     walk_start;
   walk_type     walk_first;
   walk_type     walk_final;

   assign req_stall  = q_full;
   assign accept     = req_valid && !req_stall;
   assign walk_start = '{st: '{mode: mode_ff, held: held_ff}, ent: '0};
   assign walk_first = feed(walk_start, req_data.in_byte);
   assign walk_final = (req_data.end_of_line && (walk_first.st.mode != MODE_IGNORE))
                     ? feed(walk_first, CHAR_NUL) : walk_first;

   always_comb begin
      mode_in = mode_ff;
      held_in = held_ff;
      if (accept) begin
         if (req_data.end_of_line) begin
            mode_in = MODE_SKIP;
            held_in = '0;
         end else begin
            mode_in = walk_final.st.mode;
            held_in = walk_final.st.held;
         end
      end
   end

   always_comb begin
      q_push = accept && (walk_final.ent.num != '0);
      q_data = walk_final.ent;
      for (int i = 0; i < MaxResults; i++) begin
         q_data.res[i].last_result = (walk_final.ent.num == ResNumWidth'(i + 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SKIP;
         held_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         held_ff <= held_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/qat_back.sv */
// ----------------------------------------------------------------------------
// qat_back
// Takes result groups from the queue and delivers their results one item
// per cycle on the result channel while rsp_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module qat_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   output logic                   q_pop,
   input  qat_pkg::qat_entry_type q_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output qat_pkg::qat_rsp_type   rsp_data
);
   import qat_pkg::*;

   qat_entry_type          ent_ff, ent_in;
   logic [ResIdxWidth-1:0] idx_ff, idx_in;
   logic                   vld_ff, vld_in;
   logic                   take;
   logic                   at_last;
   logic                   free;

   assign take    = vld_ff && !rsp_stall;
   assign at_last = (({1'b0, idx_ff} + ResNumWidth'(1)) == ent_ff.num);
   assign free    = !vld_ff || (take && at_last);
   assign q_pop   = free && !q_empty;

   assign rsp_valid = vld_ff;
   assign rsp_data  = ent_ff.res[idx_ff];

   always_comb begin
      ent_in = ent_ff;
      idx_in = idx_ff;
      vld_in = vld_ff;
      if (free) begin
         ent_in = q_data;
         idx_in = '0;
         vld_in = !q_empty;
      end else if (take) begin
         idx_in = idx_ff + ResIdxWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

endmodule

`default_nettype wire

/* rtl/qat_checker.sv */
// ----------------------------------------------------------------------------
// qat_checker
// Port-level checks on the request and result channels of the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quoted_argument_tokenizer_top_macros.svh"

module qat_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input qat_pkg::qat_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input qat_pkg::qat_rsp_type rsp_data
);
   import qat_pkg::*;

   logic byte_item;
   logic mark_item;
   logic byte_clean;
   logic mark_clean;

   assign byte_item  = rsp_valid && rsp_data.byte_valid;
   assign mark_item  = rsp_valid && !rsp_data.byte_valid;
   assign byte_clean = !rsp_data.token_done && !rsp_data.token_abort && !rsp_data.line_done;
   assign mark_clean = (rsp_data.token_byte == 8'h00)
                     && (!rsp_data.token_abort || (rsp_data.line_done && !rsp_data.token_done));

   // A decoded byte never carries an end mark.
   `QAT_ASSERT_NOW(a_byte_no_mark, clock, reset, byte_item, byte_clean)

   // A mark item carries a zero byte, and an abort always ends the line.
   `QAT_ASSERT_NOW(a_mark_shape, clock, reset, mark_item, mark_clean)

   // Nothing follows the end of a line within the same input byte.
   `QAT_ASSERT_NOW(a_line_last, clock, reset, rsp_valid && rsp_data.line_done, rsp_data.last_result)

   // A stalled result item stays in place.
   `QAT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // A stalled input item stays in place.
   `QAT_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable(req_data))

endmodule

bind quoted_argument_tokenizer_top qat_checker u_qat_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* test/tb_quoted_argument_tokenizer_top.sv */
// ----------------------------------------------------------------------------
// tb_quoted_argument_tokenizer_top
// The testbench feeds command lines to the tokenizer one byte per item.
// It starts with short directed lines for the special cases and then sends
// random lines, most of them well-formed and some of them damaged or noise.
// A scoreboard tracks the parse state, predicts the results of each accepted
// byte and checks every delivered result in order. Both sides idle at random,
// the receiver holds off once long enough to fill the block, and the sender
// pauses to let the block drain.
// ----------------------------------------------------------------------------
module tb_quoted_argument_tokenizer_top;
   import qat_pkg::*;

   localparam int IdleLimit   = 4000;
   localparam int LongHold    = 200;
   localparam int RandomItems = 400;
   localparam int DrainCycles = 10;

   class arg_scoreboard;
      qat_mode_type mode = MODE_SKIP;
      logic [7:0] held_digit = 8'h00;
      logic in_token = 1'b0;
      qat_rsp_type step_results[$];
      qat_rsp_type awaited[$];
      int failures = 0;

      function void clear_state();
         mode = MODE_SKIP;
         held_digit = 8'h00;
         in_token = 1'b0;
      endfunction

      function void add(logic [7:0] b, logic v, logic d, logic a, logic l);
         qat_rsp_type r;
         if (step_results.size() >= MaxResults) return;
         r.token_byte = b;
         r.byte_valid = v;
         r.token_done = d;
         r.token_abort = a;
         r.line_done = l;
         r.last_result = 1'b0;
         step_results.insert(step_results.size(), r);
      endfunction

      function void add_byte(logic [7:0] b);
         add(b, 1'b1, 1'b0, 1'b0, 1'b0);
      endfunction

      function void drop_line();
         add(CHAR_NUL, 1'b0, 1'b0, 1'b1, 1'b1);
         mode = MODE_IGNORE;
         in_token = 1'b0;
         held_digit = 8'h00;
      endfunction

      function logic is_space(logic [7:0] c);
         return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
      endfunction

      function logic is_hex(logic [7:0] c);
         return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
      endfunction

      function logic [7:0] hex_value(logic [7:0] c);
         if (c >= "a") return c - "a" + 8'd10;
         if (c >= "A") return c - "A" + 8'd10;
         return c - "0";
      endfunction

      function logic [7:0] escape_code(logic [7:0] c);
         case (c)
            CHAR_LC_N: return CHAR_LF;
            CHAR_LC_R: return CHAR_CR;
            CHAR_LC_T: return CHAR_TAB;
            CHAR_LC_B: return CHAR_BS;
            CHAR_LC_A: return CHAR_BEL;
            default: return c;
         endcase
      endfunction

      function void feed(logic [7:0] c);
         logic again;
         again = 1'b1;
         while (again) begin
            again = 1'b0;
            case (mode)
               MODE_SKIP: begin
                  if (c == CHAR_NUL) begin
                     add(CHAR_NUL, 1'b0, 1'b0, 1'b0, 1'b1);
                     mode = MODE_IGNORE;
                  end else if (!is_space(c) && c < 8'h80) begin
                     mode = MODE_UQ;
                     in_token = 1'b1;
                     again = 1'b1;
                  end
               end
               MODE_UQ: begin
                  if (c == CHAR_SPACE || c == CHAR_LF || c == CHAR_CR || c == CHAR_TAB) begin
                     add(CHAR_NUL, 1'b0, 1'b1, 1'b0, 1'b0);
                     mode = MODE_SKIP;
                     in_token = 1'b0;
                  end else if (c == CHAR_NUL) begin
                     add(CHAR_NUL, 1'b0, 1'b1, 1'b0, 1'b1);
                     mode = MODE_IGNORE;
                     in_token = 1'b0;
                  end else if (c == CHAR_DQUOT) begin
                     mode = MODE_DQ;
                  end else if (c == CHAR_SQUOT) begin
                     mode = MODE_SQ;
                  end else begin
                     add_byte(c);
                  end
               end
               MODE_DQ: begin
                  if (c == CHAR_BSL) mode = MODE_DQ_BSL;
                  else if (c == CHAR_DQUOT) mode = MODE_DQ_CLOSE;
                  else if (c == CHAR_NUL) drop_line();
                  else add_byte(c);
               end
               MODE_DQ_BSL: begin
                  if (c == CHAR_NUL) begin
                     add_byte(CHAR_BSL);
                     drop_line();
                  end else if (c == CHAR_LC_X) begin
                     mode = MODE_DQ_X;
                  end else begin
                     add_byte(escape_code(c));
                     mode = MODE_DQ;
                  end
               end
               MODE_DQ_X: begin
                  if (is_hex(c)) begin
                     held_digit = c;
                     mode = MODE_DQ_XH;
                  end else begin
                     add_byte(CHAR_LC_X);
                     mode = MODE_DQ;
                     again = 1'b1;
                  end
               end
               MODE_DQ_XH: begin
                  if (is_hex(c)) begin
                     add_byte((hex_value(held_digit) << 4) | hex_value(c));
                     held_digit = 8'h00;
                     mode = MODE_DQ;
                  end else begin
                     add_byte(CHAR_LC_X);
                     add_byte(held_digit);
                     held_digit = 8'h00;
                     mode = MODE_DQ;
                     again = 1'b1;
                  end
               end
               MODE_DQ_CLOSE, MODE_SQ_CLOSE: begin
                  if (c == CHAR_NUL) begin
                     add(CHAR_NUL, 1'b0, 1'b1, 1'b0, 1'b1);
                     mode = MODE_IGNORE;
                     in_token = 1'b0;
                  end else if (is_space(c)) begin
                     add(CHAR_NUL, 1'b0, 1'b1, 1'b0, 1'b0);
                     mode = MODE_SKIP;
                     in_token = 1'b0;
                  end else begin
                     drop_line();
                  end
               end
               MODE_SQ: begin
                  if (c == CHAR_BSL) mode = MODE_SQ_BSL;
                  else if (c == CHAR_SQUOT) mode = MODE_SQ_CLOSE;
                  else if (c == CHAR_NUL) drop_line();
                  else add_byte(c);
               end
               MODE_SQ_BSL: begin
                  if (c == CHAR_SQUOT) begin
                     add_byte(CHAR_SQUOT);
                     mode = MODE_SQ;
                  end else begin
                     add_byte(CHAR_BSL);
                     mode = MODE_SQ;
                     again = 1'b1;
                  end
               end
               default: mode = MODE_IGNORE;
            endcase
         end
      endfunction

      function void note_item(qat_req_type item);
         qat_rsp_type r;
         step_results.delete();
         feed(item.in_byte);
         if (item.end_of_line && mode != MODE_IGNORE) feed(CHAR_NUL);
         if (item.end_of_line) clear_state();
         foreach (step_results[i]) begin
            r = step_results[i];
            r.last_result = (i == step_results.size() - 1);
            awaited.insert(awaited.size(), r);
         end
      endfunction

      function void compare(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            failures++;
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
         end
      endfunction

      function void check_result(qat_rsp_type got);
         qat_rsp_type want;
         if (awaited.size() == 0) begin
            failures++;
            $display("%0t: result expected none, got %h", $time, got);
            return;
         end
         want = awaited.pop_front();
         compare("token_byte", want.token_byte, got.token_byte);
         compare("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
         compare("token_done", 8'(want.token_done), 8'(got.token_done));
         compare("token_abort", 8'(want.token_abort), 8'(got.token_abort));
         compare("line_done", 8'(want.line_done), 8'(got.line_done));
         compare("last_result", 8'(want.last_result), 8'(got.last_result));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   qat_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   qat_rsp_type rsp_data;

   arg_scoreboard board = new;
   logic [7:0] line_buf[$];
   logic calm = 1'b0;
   logic hold_request = 1'b0;
   logic holding = 1'b0;
   int sent = 0;
   int idle_cycles = 0;

   quoted_argument_tokenizer_top uut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_item(req_data);
         if (rsp_valid && !rsp_stall) board.check_result(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void append_byte(logic [7:0] b);
      line_buf.insert(line_buf.size(), b);
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      case ($urandom_range(0, 11))
         0: c = 8'($urandom_range(128, 255));
         1: c = $urandom_range(0, 1) ? 8'h0B : 8'h0C;
         default: c = 8'($urandom_range(33, 126));
      endcase
      if (c == CHAR_DQUOT || c == CHAR_SQUOT || c == CHAR_BSL) c = CHAR_LC_A;
      return c;
   endfunction

   function automatic logic [7:0] hex_char();
      string digits = "0123456789abcdefABCDEF";
      return digits[$urandom_range(0, 21)];
   endfunction

   function automatic void add_word();
      repeat ($urandom_range(1, 5)) append_byte(plain_char());
   endfunction

   function automatic void add_dq_section();
      string escapes = "nrtbaq\\\"'";
      string non_hex = "gGz! \"";
      append_byte(CHAR_DQUOT);
      repeat ($urandom_range(0, 6)) begin
         case ($urandom_range(0, 7))
            0: begin
               append_byte(CHAR_BSL);
               append_byte(escapes[$urandom_range(0, escapes.len() - 1)]);
            end
            1: begin
               append_byte(CHAR_BSL);
               append_byte(CHAR_LC_X);
               append_byte(hex_char());
               append_byte(hex_char());
            end
            2: begin
               append_byte(CHAR_BSL);
               append_byte(CHAR_LC_X);
               if ($urandom_range(0, 1)) append_byte(hex_char());
               append_byte(non_hex[$urandom_range(0, non_hex.len() - 1)]);
            end
            default: append_byte(plain_char());
         endcase
      end
      append_byte(CHAR_DQUOT);
   endfunction

   function automatic void add_sq_section();
      append_byte(CHAR_SQUOT);
      repeat ($urandom_range(0, 6)) begin
         case ($urandom_range(0, 5))
            0: begin
               append_byte(CHAR_BSL);
               append_byte(CHAR_SQUOT);
            end
            1: begin
               append_byte(CHAR_BSL);
               append_byte(plain_char());
            end
            default: append_byte(plain_char());
         endcase
      end
      append_byte(CHAR_SQUOT);
   endfunction

   function automatic void add_token();
      case ($urandom_range(0, 9))
         0, 1, 2: add_word();
         3, 4, 5: add_dq_section();
         6, 7: add_sq_section();
         default: begin
            add_word();
            add_dq_section();
         end
      endcase
   endfunction

   function automatic void add_separator();
      string spaces = " \t\r\n\013\014";
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(0, 9) == 0) append_byte(8'($urandom_range(128, 255)));
         else append_byte(spaces[$urandom_range(0, spaces.len() - 1)]);
      end
   endfunction

   function automatic void build_line();
      int tokens = $urandom_range(0, 4);
      int pos;
      line_buf.delete();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(0, 255)));
         return;
      end
      if ($urandom_range(0, 2) == 0) add_separator();
      for (int i = 0; i < tokens; i++) begin
         if (i > 0) add_separator();
         add_token();
      end
      if ($urandom_range(0, 2) == 0) add_separator();
      if (line_buf.size() > 0 && $urandom_range(0, 4) == 0) begin
         pos = $urandom_range(0, line_buf.size() - 1);
         case ($urandom_range(0, 2))
            0: line_buf[pos] = 8'($urandom_range(0, 255));
            1: while (line_buf.size() > pos + 1) void'(line_buf.pop_back());
            default: line_buf.insert(pos, CHAR_NUL);
         endcase
      end
      if ($urandom_range(0, 7) == 0) begin
         append_byte(CHAR_NUL);
         append_byte(plain_char());
      end
      if (line_buf.size() == 0) append_byte(plain_char());
   endfunction

   function automatic void load_text(string s);
      line_buf.delete();
      for (int i = 0; i < s.len(); i++) append_byte(s[i]);
   endfunction

   task automatic send_item(logic [7:0] b, logic eol);
      int gap;
      req_valid <= 1'b1;
      req_data <= '{in_byte: b, end_of_line: eol};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_buffer();
      foreach (line_buf[i]) send_item(line_buf[i], i == line_buf.size() - 1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.awaited.size() != 0) @(posedge clock);
   endtask

   initial begin
      int stall_len;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            holding = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LongHold) @(posedge clock);
            holding = 1'b0;
         end else begin
            stall_len = pick_gap();
            if (stall_len > 0) begin
               rsp_stall <= 1'b1;
               repeat (stall_len) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, calm ? 1 : 12)) @(posedge clock);
      end
   end

   initial begin
      int line_count;
      line_count = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      load_text("\377\013a\377\014 \"\\x4g\\xz\"");
      send_buffer();
      load_text("'\\'\\z'xq");
      send_buffer();
      load_text("\"\\");
      send_buffer();
      send_item(CHAR_LC_A, 1'b0);
      send_item(CHAR_NUL, 1'b0);
      send_item(CHAR_LC_B, 1'b1);
      wait_drained();

      while (sent < RandomItems) begin
         calm = (line_count % 7 == 2);
         if (line_count == 6) begin
            req_valid <= 1'b0;
            @(posedge clock);
            hold_request = 1'b1;
            wait (holding);
            calm = 1'b1;
            repeat (3) begin
               build_line();
               send_buffer();
            end
            calm = 1'b0;
         end
         if (line_count == 12 || line_count == 20) wait_drained();
         build_line();
         send_buffer();
         line_count++;
      end
      calm = 1'b0;

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      @(negedge clock);
      if (board.failures == 0 && board.awaited.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
